// ===== src/tsdz_pkg.sv =====
// Shared types and constants for the thumbstick dead-zone pipeline.
// No dependencies.
`default_nettype none
package tsdz_pkg;

  localparam int IN_W  = 16;   // stick sample width
  localparam int DEN_W = 16;   // divisor width (zone span or vector length)
  localparam int CFG_W = 15;   // widest config register
  localparam int SQ_W  = 32;   // x*x + y*y
  localparam int RT_W  = 16;   // integer root of SQ_W

  // zone_mode codes
  localparam logic [1:0] MODE_AXIAL  = 2'd0;
  localparam logic [1:0] MODE_RADIAL = 2'd1;
  localparam logic [1:0] MODE_NONE   = 2'd2;

  // config register indexes
  localparam logic [1:0] CFG_MODE  = 2'd0;
  localparam logic [1:0] CFG_SCALE = 2'd1;
  localparam logic [1:0] CFG_ZONE  = 2'd2;

  // per-lane divider flags
  typedef struct packed {
    logic zero;  // value inside the dead zone, result 0
    logic sat;   // result is full scale
  } tsdz_flag_t;

endpackage
`default_nettype wire

// ===== src/tsdz_isqrt.sv =====
// Pipelined integer square root, two result bits per stage.
// Depends on tsdz_pkg.
`default_nettype none
module tsdz_isqrt #(
  parameter int SIDE_W = 8
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  input  wire logic [tsdz_pkg::SQ_W-1:0] in_rad,
  input  wire logic [SIDE_W-1:0]         in_side,
  output logic                           out_valid,
  output logic [tsdz_pkg::RT_W-1:0]      out_root,
  output logic [SIDE_W-1:0]              out_side
);
  import tsdz_pkg::*;

  localparam int NSTG  = RT_W / 2;
  localparam int REM_W = RT_W + 4;

  logic              vld_r  [1:NSTG];
  logic [SQ_W-1:0]   rad_r  [1:NSTG];
  logic [REM_W-1:0]  rem_r  [1:NSTG];
  logic [RT_W-1:0]   root_r [1:NSTG];
  logic [SIDE_W-1:0] side_r [1:NSTG];

  logic [SQ_W-1:0]   rad_nxt  [1:NSTG];
  logic [REM_W-1:0]  rem_nxt  [1:NSTG];
  logic [RT_W-1:0]   root_nxt [1:NSTG];

  genvar s;
  generate
    for (s = 1; s <= NSTG; s++) begin : g_stg
      logic              src_vld;
      logic [SQ_W-1:0]   src_rad;
      logic [REM_W-1:0]  src_rem;
      logic [RT_W-1:0]   src_root;
      logic [SIDE_W-1:0] src_side;

      if (s == 1) begin : g_first
        assign src_vld  = in_valid;
        assign src_rad  = in_rad;
        assign src_rem  = '0;
        assign src_root = '0;
        assign src_side = in_side;
      end else begin : g_rest
        assign src_vld  = vld_r[s-1];
        assign src_rad  = rad_r[s-1];
        assign src_rem  = rem_r[s-1];
        assign src_root = root_r[s-1];
        assign src_side = side_r[s-1];
      end

      always_comb begin
        logic [REM_W-1:0] rem_v;
        logic [SQ_W-1:0]  rad_v;
        logic [RT_W-1:0]  root_v;
        logic [REM_W-1:0] trial;
        rem_v  = src_rem;
        rad_v  = src_rad;
        root_v = src_root;
        for (int j = 0; j < 2; j++) begin
          rem_v = {rem_v[REM_W-3:0], rad_v[SQ_W-1:SQ_W-2]};
          rad_v = {rad_v[SQ_W-3:0], 2'b00};
          trial = REM_W'({root_v, 2'b01});
          if (rem_v >= trial) begin
            rem_v  = rem_v - trial;
            root_v = {root_v[RT_W-2:0], 1'b1};
          end else begin
            root_v = {root_v[RT_W-2:0], 1'b0};
          end
        end
        rad_nxt[s]  = rad_v;
        rem_nxt[s]  = rem_v;
        root_nxt[s] = root_v;
      end

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          vld_r[s] <= 1'b0;
        end else begin
          vld_r[s] <= src_vld;
        end
      end

      always_ff @(posedge clk) begin
        rad_r[s]  <= rad_nxt[s];
        rem_r[s]  <= rem_nxt[s];
        root_r[s] <= root_nxt[s];
        side_r[s] <= src_side;
      end
    end
  endgenerate

  assign out_valid = vld_r[NSTG];
  assign out_root  = root_r[NSTG];
  assign out_side  = side_r[NSTG];

endmodule
`default_nettype wire

// ===== src/tsdz_div.sv =====
// Two-lane pipelined restoring divider with a shared divisor, two quotient
// bits per stage, overflow flagged as saturation. Depends on tsdz_pkg.
`default_nettype none
module tsdz_div #(
  parameter int NUM_W  = 32,
  parameter int Q_W    = 15,
  parameter int SIDE_W = 8
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  input  wire logic [tsdz_pkg::DEN_W-1:0] in_den,
  input  wire logic [NUM_W-1:0]           in_num_x,
  input  wire logic [NUM_W-1:0]           in_num_y,
  input  wire tsdz_pkg::tsdz_flag_t       in_flag_x,
  input  wire tsdz_pkg::tsdz_flag_t       in_flag_y,
  input  wire logic [SIDE_W-1:0]          in_side,
  output logic                            out_valid,
  output logic [Q_W-1:0]                  out_q_x,
  output logic [Q_W-1:0]                  out_q_y,
  output tsdz_pkg::tsdz_flag_t            out_flag_x,
  output tsdz_pkg::tsdz_flag_t            out_flag_y,
  output logic [SIDE_W-1:0]               out_side
);
  import tsdz_pkg::*;

  localparam int NSTG = (Q_W + 1) / 2;

  logic              vld_r  [0:NSTG];
  logic [DEN_W-1:0]  den_r  [0:NSTG];
  logic [NUM_W-1:0]  rem_r  [0:NSTG][0:1];
  logic [Q_W-1:0]    q_r    [0:NSTG][0:1];
  tsdz_flag_t        flag_r [0:NSTG][0:1];
  logic [SIDE_W-1:0] side_r [0:NSTG];

  logic [NUM_W-1:0]  num_in  [0:1];
  tsdz_flag_t        flag_in [0:1];
  logic [NUM_W-1:0]  thresh;

  assign num_in[0]  = in_num_x;
  assign num_in[1]  = in_num_y;
  assign flag_in[0] = in_flag_x;
  assign flag_in[1] = in_flag_y;
  // quotient would need more than Q_W bits
  assign thresh = NUM_W'({in_den, {Q_W{1'b0}}});

  // entry stage: overflow check
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else begin
      vld_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    den_r[0]  <= in_den;
    side_r[0] <= in_side;
    for (int l = 0; l < 2; l++) begin
      rem_r[0][l]       <= num_in[l];
      q_r[0][l]         <= '0;
      flag_r[0][l].zero <= flag_in[l].zero;
      flag_r[0][l].sat  <= flag_in[l].sat | (num_in[l] >= thresh);
    end
  end

  genvar s, l;
  generate
    for (s = 1; s <= NSTG; s++) begin : g_stg
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          vld_r[s] <= 1'b0;
        end else begin
          vld_r[s] <= vld_r[s-1];
        end
      end

      always_ff @(posedge clk) begin
        den_r[s]  <= den_r[s-1];
        side_r[s] <= side_r[s-1];
      end

      for (l = 0; l < 2; l++) begin : g_lane
        logic [NUM_W-1:0] rem_nxt;
        logic [Q_W-1:0]   q_nxt;

        always_comb begin
          int               idx;
          logic [NUM_W-1:0] shd;
          rem_nxt = rem_r[s-1][l];
          q_nxt   = q_r[s-1][l];
          for (int j = 0; j < 2; j++) begin
            idx = Q_W - 1 - (2 * (s - 1) + j);
            if (idx >= 0) begin
              shd = NUM_W'(den_r[s-1]) << idx;
              if (rem_nxt >= shd) begin
                rem_nxt    = rem_nxt - shd;
                q_nxt[idx] = 1'b1;
              end
            end
          end
        end

        always_ff @(posedge clk) begin
          rem_r[s][l]  <= rem_nxt;
          q_r[s][l]    <= q_nxt;
          flag_r[s][l] <= flag_r[s-1][l];
        end
      end
    end
  endgenerate

  assign out_valid  = vld_r[NSTG];
  assign out_q_x    = q_r[NSTG][0];
  assign out_q_y    = q_r[NSTG][1];
  assign out_flag_x = flag_r[NSTG][0];
  assign out_flag_y = flag_r[NSTG][1];
  assign out_side   = side_r[NSTG];

endmodule
`default_nettype wire

// ===== src/thumbstick_dead_zone.sv =====
// Top level of the thumbstick dead-zone conditioner.
// Uses tsdz_pkg, tsdz_isqrt and tsdz_div.
`default_nettype none
// One stick sample (in_stick_x, in_stick_y) enters on start; busy is always
// low, so a new sample may be given every cycle. Each sample returns exactly
// one word (out_x, out_y) on out_valid, held for a single cycle, in order.
// The path runs through the pipelined root (8 stages) and two pipelined
// dividers (one entry stage plus one stage per two quotient bits). The
// receiver cannot stall the output, and there is no backpressure. Config
// writes are always taken (cfg_ready high) and must only be made with no
// sample in flight; zone_mode 3 acts as no dead zone.
module thumbstick_dead_zone #(
  parameter int FRAC_BITS = 14
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  output logic                            busy,
  input  wire logic signed [15:0]         in_stick_x,
  input  wire logic signed [15:0]         in_stick_y,
  output logic                            out_valid,
  output logic signed [15:0]              out_x,
  output logic signed [15:0]              out_y,
  input  wire logic                       cfg_valid,
  output logic                            cfg_ready,
  input  wire logic [1:0]                 cfg_index,
  input  wire logic [tsdz_pkg::CFG_W-1:0] cfg_data
);
  import tsdz_pkg::*;

  localparam int ONE_W  = FRAC_BITS + 1;          // magnitude up to 1.0
  localparam int NUM_W  = FRAC_BITS + 18;         // dividend width
  localparam int SIDE1_W = 2 + 2 * IN_W;          // signs, magnitudes
  localparam int SIDE2_W = SIDE1_W + RT_W;        // ... plus length
  localparam int SIDE3_W = 3 + 2 * ONE_W;         // signs, bypass, results
  localparam logic [ONE_W-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

  // ---------------- config registers ----------------
  logic [1:0]       zone_mode_r;
  logic [CFG_W-1:0] full_scale_r;
  logic [CFG_W-1:0] zone_size_r;

  assign cfg_ready = 1'b1;
  assign busy      = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zone_mode_r  <= MODE_AXIAL;
      full_scale_r <= CFG_W'(16384);
      zone_size_r  <= CFG_W'(3932);
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_MODE:  zone_mode_r  <= cfg_data[1:0];
        CFG_SCALE: full_scale_r <= cfg_data;
        CFG_ZONE:  zone_size_r  <= cfg_data;
        default:   ;
      endcase
    end
  end

  logic radial;
  assign radial = (zone_mode_r == MODE_RADIAL);

  // ---------------- s1: capture ----------------
  logic              s1_vld_r;
  logic signed [15:0] s1_x_r, s1_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= start;
    end
  end

  always_ff @(posedge clk) begin
    s1_x_r <= in_stick_x;
    s1_y_r <= in_stick_y;
  end

  // ---------------- s2: magnitudes and squares ----------------
  logic             s2_vld_r;
  logic             s2_sx_r, s2_sy_r;
  logic [IN_W-1:0]  s2_ax_r, s2_ay_r;
  logic [SQ_W-1:0]  s2_sqx_r, s2_sqy_r;
  logic [IN_W-1:0]  ax_nxt, ay_nxt;
  logic signed [31:0] sqx_full, sqy_full;

  assign ax_nxt   = s1_x_r[15] ? (16'd0 - s1_x_r) : s1_x_r;  // -32768 -> 32768
  assign ay_nxt   = s1_y_r[15] ? (16'd0 - s1_y_r) : s1_y_r;
  assign sqx_full = s1_x_r * s1_x_r;
  assign sqy_full = s1_y_r * s1_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s2_sx_r  <= s1_x_r[15];
    s2_sy_r  <= s1_y_r[15];
    s2_ax_r  <= ax_nxt;
    s2_ay_r  <= ay_nxt;
    s2_sqx_r <= sqx_full;
    s2_sqy_r <= sqy_full;
  end

  // ---------------- s3: squared length ----------------
  logic               s3_vld_r;
  logic [SQ_W-1:0]    s3_sq_r;
  logic [SIDE1_W-1:0] s3_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else begin
      s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s3_sq_r   <= s2_sqx_r + s2_sqy_r;  // at most 2^31, no carry out
    s3_side_r <= {s2_sx_r, s2_sy_r, s2_ax_r, s2_ay_r};
  end

  // ---------------- vector length ----------------
  logic               rt_vld;
  logic [RT_W-1:0]    rt_dist;
  logic [SIDE1_W-1:0] rt_side;

  tsdz_isqrt #(.SIDE_W(SIDE1_W)) u_isqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s3_vld_r),
    .in_rad    (s3_sq_r),
    .in_side   (s3_side_r),
    .out_valid (rt_vld),
    .out_root  (rt_dist),
    .out_side  (rt_side)
  );

  // ---------------- zn: dead zone and first dividend ----------------
  logic [IN_W-1:0]   rt_ax, rt_ay;
  logic              rt_sx, rt_sy;
  logic [CFG_W-1:0]  dz_eff;
  logic signed [16:0] span;
  logic              span_ok;
  logic [DEN_W-1:0]  den1;
  logic [IN_W-1:0]   lv_x, lv_y;
  logic [NUM_W-1:0]  num1_x, num1_y;
  tsdz_flag_t        flg1_x, flg1_y;

  assign {rt_sx, rt_sy, rt_ax, rt_ay} = rt_side;

  always_comb begin
    // no dead zone in modes 2 and 3
    dz_eff  = (zone_mode_r == MODE_AXIAL || radial) ? zone_size_r : '0;
    span    = $signed({2'b00, full_scale_r}) - $signed({2'b00, dz_eff});
    span_ok = !span[16] && (span != 17'sd0);
    den1    = span_ok ? span[15:0] : DEN_W'(1);
    lv_x    = radial ? rt_dist : rt_ax;
    lv_y    = rt_ay;

    flg1_x.zero = !(lv_x > IN_W'(dz_eff));
    flg1_x.sat  = !span_ok;
    num1_x      = (NUM_W'(lv_x - IN_W'(dz_eff)) << FRAC_BITS) + NUM_W'(den1[DEN_W-1:1]);

    // the y lane is unused for the radial case
    flg1_y.zero = radial || !(lv_y > IN_W'(dz_eff));
    flg1_y.sat  = !span_ok;
    num1_y      = (NUM_W'(lv_y - IN_W'(dz_eff)) << FRAC_BITS) + NUM_W'(den1[DEN_W-1:1]);
  end

  logic               zn_vld_r;
  logic [DEN_W-1:0]   zn_den_r;
  logic [NUM_W-1:0]   zn_num_x_r, zn_num_y_r;
  tsdz_flag_t         zn_flg_x_r, zn_flg_y_r;
  logic [SIDE2_W-1:0] zn_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zn_vld_r <= 1'b0;
    end else begin
      zn_vld_r <= rt_vld;
    end
  end

  always_ff @(posedge clk) begin
    zn_den_r   <= den1;
    zn_num_x_r <= num1_x;
    zn_num_y_r <= num1_y;
    zn_flg_x_r <= flg1_x;
    zn_flg_y_r <= flg1_y;
    zn_side_r  <= {rt_side, rt_dist};
  end

  // ---------------- divider 1: rescale past the dead zone ----------------
  logic               d1_vld;
  logic [ONE_W-1:0]   d1_q_x, d1_q_y;
  tsdz_flag_t         d1_flg_x, d1_flg_y;
  logic [SIDE2_W-1:0] d1_side;

  tsdz_div #(.NUM_W(NUM_W), .Q_W(ONE_W), .SIDE_W(SIDE2_W)) u_div_zone (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (zn_vld_r),
    .in_den     (zn_den_r),
    .in_num_x   (zn_num_x_r),
    .in_num_y   (zn_num_y_r),
    .in_flag_x  (zn_flg_x_r),
    .in_flag_y  (zn_flg_y_r),
    .in_side    (zn_side_r),
    .out_valid  (d1_vld),
    .out_q_x    (d1_q_x),
    .out_q_y    (d1_q_y),
    .out_flag_x (d1_flg_x),
    .out_flag_y (d1_flg_y),
    .out_side   (d1_side)
  );

  // zero, saturate or clamp a quotient to [0, 1.0]
  function automatic logic [ONE_W-1:0] fold(input tsdz_flag_t f, input logic [ONE_W-1:0] q);
    logic [ONE_W-1:0] r;
    if (f.zero) begin
      r = '0;
    end else if (f.sat || q > ONE) begin
      r = ONE;
    end else begin
      r = q;
    end
    return r;
  endfunction

  // ---------------- w1: wanted length times each axis ----------------
  logic             d1_sx, d1_sy;
  logic [IN_W-1:0]  d1_ax, d1_ay;
  logic [RT_W-1:0]  d1_dist;
  logic [ONE_W-1:0] mag1_x, mag1_y;

  assign {d1_sx, d1_sy, d1_ax, d1_ay, d1_dist} = d1_side;
  assign mag1_x = fold(d1_flg_x, d1_q_x);
  assign mag1_y = fold(d1_flg_y, d1_q_y);

  logic                 w1_vld_r;
  logic                 w1_sx_r, w1_sy_r, w1_act_r;
  logic [ONE_W-1:0]     w1_res_x_r, w1_res_y_r;
  logic [IN_W+ONE_W-1:0] w1_prod_x_r, w1_prod_y_r;
  logic [RT_W-1:0]      w1_dist_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w1_vld_r <= 1'b0;
    end else begin
      w1_vld_r <= d1_vld;
    end
  end

  always_ff @(posedge clk) begin
    w1_sx_r     <= d1_sx;
    w1_sy_r     <= d1_sy;
    w1_act_r    <= (mag1_x != '0) && (d1_dist != '0);
    w1_res_x_r  <= mag1_x;
    w1_res_y_r  <= mag1_y;
    w1_prod_x_r <= d1_ax * mag1_x;
    w1_prod_y_r <= d1_ay * mag1_x;
    w1_dist_r   <= d1_dist;
  end

  // ---------------- w2: second dividend ----------------
  logic       w2_use_div;
  tsdz_flag_t flg2;
  logic [DEN_W-1:0] den2;
  logic [NUM_W-1:0] num2_x, num2_y;

  always_comb begin
    // in the radial case the divider gives the result, else it is bypassed
    w2_use_div = radial;
    flg2.zero  = !(radial && w1_act_r);
    flg2.sat   = 1'b0;
    den2       = w1_act_r ? w1_dist_r : DEN_W'(1);
    num2_x     = NUM_W'(w1_prod_x_r) + NUM_W'(den2[DEN_W-1:1]);
    num2_y     = NUM_W'(w1_prod_y_r) + NUM_W'(den2[DEN_W-1:1]);
  end

  logic               w2_vld_r;
  logic [DEN_W-1:0]   w2_den_r;
  logic [NUM_W-1:0]   w2_num_x_r, w2_num_y_r;
  tsdz_flag_t         w2_flg_r;
  logic [SIDE3_W-1:0] w2_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w2_vld_r <= 1'b0;
    end else begin
      w2_vld_r <= w1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    w2_den_r   <= den2;
    w2_num_x_r <= num2_x;
    w2_num_y_r <= num2_y;
    w2_flg_r   <= flg2;
    w2_side_r  <= {w1_sx_r, w1_sy_r, w2_use_div, w1_res_x_r, w1_res_y_r};
  end

  // ---------------- divider 2: scale axes by wanted/length ----------------
  logic               d2_vld;
  logic [ONE_W-1:0]   d2_q_x, d2_q_y;
  tsdz_flag_t         d2_flg_x, d2_flg_y;
  logic [SIDE3_W-1:0] d2_side;

  tsdz_div #(.NUM_W(NUM_W), .Q_W(ONE_W), .SIDE_W(SIDE3_W)) u_div_axis (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (w2_vld_r),
    .in_den     (w2_den_r),
    .in_num_x   (w2_num_x_r),
    .in_num_y   (w2_num_y_r),
    .in_flag_x  (w2_flg_r),
    .in_flag_y  (w2_flg_r),
    .in_side    (w2_side_r),
    .out_valid  (d2_vld),
    .out_q_x    (d2_q_x),
    .out_q_y    (d2_q_y),
    .out_flag_x (d2_flg_x),
    .out_flag_y (d2_flg_y),
    .out_side   (d2_side)
  );

  // ---------------- output word ----------------
  logic             d2_sx, d2_sy, d2_use;
  logic [ONE_W-1:0] d2_res_x, d2_res_y;
  logic [ONE_W-1:0] fin_x, fin_y;
  logic [31:0]      ext_x, ext_y;
  logic [15:0]      out_x_nxt, out_y_nxt;

  assign {d2_sx, d2_sy, d2_use, d2_res_x, d2_res_y} = d2_side;

  always_comb begin
    fin_x     = d2_use ? fold(d2_flg_x, d2_q_x) : d2_res_x;
    fin_y     = d2_use ? fold(d2_flg_y, d2_q_y) : d2_res_y;
    ext_x     = 32'(fin_x);
    ext_y     = 32'(fin_y);
    // sign follows the input axis; result is kept to 16 bits
    out_x_nxt = d2_sx ? 16'(32'd0 - ext_x) : ext_x[15:0];
    out_y_nxt = d2_sy ? 16'(32'd0 - ext_y) : ext_y[15:0];
  end

  logic               out_vld_r;
  logic signed [15:0] out_x_r, out_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= d2_vld;
    end
  end

  always_ff @(posedge clk) begin
    out_x_r <= out_x_nxt;
    out_y_r <= out_y_nxt;
  end

  assign out_valid = out_vld_r;
  assign out_x     = out_x_r;
  assign out_y     = out_y_r;

endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
// Testbench for thumbstick_dead_zone: directed and random stick samples checked
// against an in-bench model of the dead-zone math. Depends on tsdz_pkg and the block.
`timescale 1ns / 100ps

module testbench;
  import tsdz_pkg::*;

  localparam int FRAC = 14;
  localparam int LATENCY = 17 + 2 * ((FRAC + 2) / 2);

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
  } stick_word_t;

  // Scoreboard: predicts each accepted sample and checks outputs in order.
  class stick_scoreboard;
    logic [1:0]  mode;
    logic [14:0] scale;
    logic [14:0] zone;
    stick_word_t pending[$];
    int          errors;

    function new();
      mode = MODE_AXIAL;
      scale = 15'd16384;
      zone = 15'd3932;
      errors = 0;
    endfunction

    function longint unit_val();
      return longint'(1) << FRAC;
    endfunction

    function longint clamp1(longint v);
      if (v > unit_val()) return unit_val();
      if (v < -unit_val()) return -unit_val();
      return v;
    endfunction

    // round to nearest, ties away from zero
    function longint rdiv(longint num, longint den);
      longint mag;
      longint q;
      mag = (num < 0) ? -num : num;
      q = (mag + den / 2) / den;
      return (num < 0) ? -q : q;
    endfunction

    function longint zone_shift(longint v, longint maxv, longint dz);
      longint den;
      if (v < -dz) v = v + dz;
      else if (v > dz) v = v - dz;
      else return 0;
      den = maxv - dz;
      if (den <= 0) return (v < 0) ? -unit_val() : unit_val();
      return clamp1(rdiv(v * unit_val(), den));
    endfunction

    function longint int_root(longint n);
      longint r;
      r = 0;
      while ((r + 1) * (r + 1) <= n) begin
        // coarse steps first keeps the loop short
        if ((r + 256) * (r + 256) <= n) r = r + 256;
        else r = r + 1;
      end
      return r;
    endfunction

    function void note_sample(logic signed [15:0] sx, logic signed [15:0] sy);
      longint x, y, rx, ry, vec_len, wanted;
      stick_word_t w;
      x = sx;
      y = sy;
      if (mode == MODE_AXIAL) begin
        rx = zone_shift(x, scale, zone);
        ry = zone_shift(y, scale, zone);
      end else if (mode == MODE_RADIAL) begin
        vec_len = int_root(x * x + y * y);
        wanted = zone_shift(vec_len, scale, zone);
        if (wanted > 0 && vec_len > 0) begin
          rx = clamp1(rdiv(x * wanted, vec_len));
          ry = clamp1(rdiv(y * wanted, vec_len));
        end else begin
          rx = 0;
          ry = 0;
        end
      end else begin
        rx = zone_shift(x, scale, 0);
        ry = zone_shift(y, scale, 0);
      end
      w.x = rx[15:0];
      w.y = ry[15:0];
      pending.push_back(w);
    endfunction

    function void check_word(logic signed [15:0] ax, logic signed [15:0] ay);
      stick_word_t w;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected word x=%0d y=%0d", ax, ay);
        return;
      end
      w = pending.pop_front();
      if (w.x !== ax || w.y !== ay) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: exp x=%0d y=%0d got x=%0d y=%0d", w.x, w.y, ax, ay);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  logic signed [15:0] in_stick_x, in_stick_y;
  logic out_valid;
  logic signed [15:0] out_x, out_y;
  logic cfg_valid;
  logic cfg_ready;
  logic [1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;

  stick_scoreboard sb;

  thumbstick_dead_zone #(.FRAC_BITS(FRAC)) i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_stick_x(in_stick_x), .in_stick_y(in_stick_y),
    .out_valid(out_valid), .out_x(out_x), .out_y(out_y),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Output monitor: every strobed word is taken, the receiver never stalls.
  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_word(out_x, out_y);
  end

  // Mostly short gaps, now and then a long one.
  function automatic int gap_len();
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
    if ($urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 3);
  endfunction

  // Valid stays high across back-to-back writes; set_config drops it.
  task automatic write_reg(logic [1:0] idx, logic [CFG_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    // model takes the value once the write is accepted
    if (idx == CFG_MODE) sb.mode = val[1:0];
    else if (idx == CFG_SCALE) sb.scale = val;
    else sb.zone = val;
  endtask

  // Block must be drained before any register changes.
  task automatic drain();
    start <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic set_config(logic [1:0] m, logic [14:0] s, logic [14:0] z);
    drain();
    write_reg(CFG_MODE, {13'd0, m});
    write_reg(CFG_SCALE, s);
    write_reg(CFG_ZONE, z);
    cfg_valid <= 1'b0;
  endtask

  // Holds start high back to back when the gap is zero.
  task automatic send_sample(logic signed [15:0] sx, logic signed [15:0] sy, int gap);
    start <= 1'b1;
    in_stick_x <= sx;
    in_stick_y <= sy;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_sample(sx, sy);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Random sample: biased toward edges of the zone and full scale.
  function automatic logic signed [15:0] pick_axis(logic [14:0] s, logic [14:0] z);
    int k;
    int v;
    k = $urandom_range(0, 9);
    if (k < 4) return 16'($urandom());
    if (k < 6) v = int'(z) + $urandom_range(0, 8) - 4;
    else if (k < 8) v = int'(s) + $urandom_range(0, 8) - 4;
    else v = $urandom_range(0, 300);
    if (v > 32767) v = 32767;
    if ($urandom_range(0, 1)) v = -v;
    return v[15:0];
  endfunction

  logic [1:0] rm;
  logic [14:0] rs, rz;
  int phase;
  int n;

  initial begin
    sb = new();
    rst_n = 1'b0;
    start = 1'b0;
    in_stick_x = '0;
    in_stick_y = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset settings, extremes, inside and on the zone edge.
    send_sample(16'sd0, 16'sd0, 0);
    send_sample(16'sh7fff, 16'sh8000, 0);
    send_sample(16'sd3932, -16'sd3932, 1);
    send_sample(16'sd3933, -16'sd3933, 0);
    send_sample(16'sd16384, -16'sd16384, 2);
    send_sample(16'sh8000, 16'sh7fff, 0);
    // Radial mode, including a point just past the zone along the diagonal.
    set_config(MODE_RADIAL, 15'd16384, 15'd3932);
    send_sample(16'sd0, 16'sd0, 0);
    send_sample(16'sh8000, 16'sh8000, 0);
    send_sample(16'sd2781, 16'sd2781, 0);
    send_sample(16'sd2790, -16'sd2790, 0);
    send_sample(16'sh7fff, 16'sd5, 3);
    // No dead zone, then mode 3 which acts the same.
    set_config(MODE_NONE, 15'd16384, 15'd100);
    send_sample(16'sd1, -16'sd1, 0);
    send_sample(16'sh7fff, 16'sh8000, 0);
    set_config(2'd3, 15'd1, 15'd0);
    send_sample(16'sd1, -16'sd1, 0);
    send_sample(16'sd0, 16'sh7fff, 0);
    // Empty or negative scale range: any value past the zone saturates; then full scale, no zone.
    set_config(MODE_AXIAL, 15'd100, 15'd100);
    send_sample(16'sd101, -16'sd101, 0);
    send_sample(16'sd100, -16'sd50, 0);
    set_config(MODE_RADIAL, 15'd1, 15'h7fff);
    send_sample(16'sh8000, 16'sh8000, 0);
    send_sample(16'sh7fff, 16'sd0, 0);
    set_config(MODE_AXIAL, 15'h7fff, 15'd0);
    send_sample(16'sh8000, 16'sh7fff, 0);
    send_sample(16'sd1, -16'sd1, 0);

    // Random phases over varied register settings.
    for (phase = 0; phase < 17; phase++) begin
      rm = 2'($urandom_range(0, 3));
      case ($urandom_range(0, 3))
        0: begin
          rs = 15'd16384;
          rz = 15'($urandom_range(0, 8000));
        end
        1: begin
          rs = 15'($urandom_range(1, 32767));
          rz = 15'($urandom_range(0, 32767));
        end
        2: begin
          rs = 15'h7fff;
          rz = 15'($urandom_range(0, 3));
        end
        default: begin
          rs = 15'($urandom_range(1, 200));
          rz = 15'($urandom_range(0, 300));
        end
      endcase
      set_config(rm, rs, rz);
      for (n = 0; n < 50; n++) send_sample(pick_axis(rs, rz), pick_axis(rs, rz), gap_len());
    end

    drain();
    if (sb.errors == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("testbench NOT OK");
    $finish;
  end
endmodule

// ===== filelist.f =====
src/tsdz_pkg.sv
src/tsdz_isqrt.sv
src/tsdz_div.sv
src/thumbstick_dead_zone.sv
tb/testbench.sv
